// ===== rtl/nrzts_pkg.sv =====
// ============================================================================
// nrzts_pkg
// Shared types and constants for the NRZ edge timestamp encoder.
// ============================================================================
package nrzts_pkg;

  localparam int unsigned MsgBits   = 21;  // message length, sent MSB first
  localparam int unsigned TimeW     = 16;  // running time, half-bit units
  localparam int unsigned SlotW     = 12;  // playback slot index
  localparam int unsigned BitUnits  = 2;   // half-bit units per message bit
  localparam int unsigned IdleUnits = 4;   // two idle bits after a message
  localparam int unsigned MsgUnits  = BitUnits * MsgBits + IdleUnits;

  localparam int unsigned DefaultBufferDepth = 4096;
  localparam int unsigned QueueDepth         = 2;

  // One classified message: bit k set means a level change at the boundary
  // that is scanned (MsgBits-1-k) steps after the first one.
  typedef struct packed {
    logic [MsgBits-1:0] edge_mask;
    logic [TimeW-1:0]   first_time;  // time of the first bit boundary
    logic               restart;
  } q_entry_t;

endpackage

// ===== rtl/nrzts_front.sv =====
// ============================================================================
// nrzts_front
// Accepts messages, keeps running time and turns bits into an edge mask.
// ============================================================================
module nrzts_front
  import nrzts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [MsgBits-1:0] message_bits_i,
  input  logic               restart_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output q_entry_t           q_entry_o
);

  logic [TimeW-1:0] time_q, time_d;
  logic [TimeW-1:0] start_time;
  logic [MsgBits:0] ext_bits;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  assign start_time = restart_i ? '0 : time_q;

  // Trailing zero stands for the line level after the message: a final one
  // then yields the end edge.
  assign ext_bits = {message_bits_i, 1'b0};

  always_comb begin
    q_entry_o.edge_mask  = ext_bits[MsgBits:1] ^ ext_bits[MsgBits-1:0];
    q_entry_o.first_time = start_time + TimeW'(BitUnits);
    q_entry_o.restart    = restart_i;
  end

  assign time_d = q_push_o ? start_time + TimeW'(MsgUnits) : time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else begin
      time_q <= time_d;
    end
  end

endmodule

// ===== rtl/nrzts_queue.sv =====
// ============================================================================
// nrzts_queue
// Small FIFO of classified messages between front and back.
// ============================================================================
module nrzts_queue
  import nrzts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/nrzts_back.sv =====
// ============================================================================
// nrzts_back
// Scans an edge mask one boundary per unstalled cycle; emits timestamped edges.
// ============================================================================
module nrzts_back
  import nrzts_pkg::*;
#(
  parameter int unsigned BufferDepth = DefaultBufferDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  q_entry_t         q_entry_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [TimeW-1:0] edge_time_o,
  output logic [SlotW-1:0] edge_slot_o,
  output logic             last_edge_o
);

  // Slot counter is SlotW bits wide, so it never reaches beyond 2**SlotW.
  localparam int unsigned SlotWrap =
    (BufferDepth > (1 << SlotW)) ? (1 << SlotW) : BufferDepth;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SlotWrap - 1);

  logic [MsgBits-1:0] mask_q, mask_d;
  logic [TimeW-1:0]   time_q, time_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               out_valid_q, out_valid_d;
  logic [TimeW-1:0]   out_time_q;
  logic [SlotW-1:0]   out_slot_q;
  logic               out_last_q;
  logic               busy, advance, step, emit;

  assign busy    = (mask_q != '0);
  assign advance = !out_valid_q || pop;
  assign step    = busy && advance;
  assign emit    = step && mask_q[MsgBits-1];
  assign q_pop_o = !busy && q_valid_i;

  always_comb begin
    mask_d      = mask_q;
    time_d      = time_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      mask_d = q_entry_i.edge_mask;
      time_d = q_entry_i.first_time;
      if (q_entry_i.restart) begin
        slot_d = '0;
      end
    end else if (step) begin
      mask_d = mask_q << 1;
      time_d = time_q + TimeW'(BitUnits);
    end
    if (emit) begin
      slot_d = (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
    end
    if (advance) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    if (emit) begin
      out_time_q <= time_q;
      out_slot_q <= slot_q;
      out_last_q <= (mask_q[MsgBits-2:0] == '0);
    end
  end

  assign empty       = !out_valid_q;
  assign edge_time_o = out_time_q;
  assign edge_slot_o = out_slot_q;
  assign last_edge_o = out_last_q;

endmodule

// ===== rtl/nrz_edge_timestamp_encoder_core.sv =====
// ============================================================================
// nrz_edge_timestamp_encoder_core
// Serialises 21-bit messages onto an NRZ line as timestamped level changes.
// ============================================================================
// Each transfer on the input queue side carries one 21-bit message (bit 20
// first) and a restart flag. Every bit lasts two half-bit units on a wrapping
// 16-bit clock; each level change between neighbouring bits comes out as one
// result transfer with its boundary timestamp and playback slot, a final one
// bit adds an end edge, and last_edge_o marks the final edge of the message.
// A message of all zeros gives no result. After the message the time moves
// on by two idle bits, so consecutive messages are 46 units apart; restart
// clears time and slot before the message is encoded. Slots count up and
// wrap at BufferDepth (at most 4096). The front stores a message in a
// two-entry queue in the cycle it is pushed; the back takes it out once it
// is idle and then walks the 21 bit boundaries with a shift register, one
// per cycle while the output is not held, and stops after the last edge; a
// message with no edges takes no walk. Edges leave through a single output
// register at up to one per cycle; every cycle in which a waiting result is
// not popped holds the walk for that cycle. full stays low while the queue
// has room, so up to two messages may be queued behind the one being walked.
// ============================================================================
module nrz_edge_timestamp_encoder_core
  import nrzts_pkg::*;
#(
  parameter int unsigned BufferDepth = DefaultBufferDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // message side
  input  logic               push,
  output logic               full,
  input  logic [MsgBits-1:0] message_bits_i,
  input  logic               restart_i,
  // edge side
  output logic               empty,
  input  logic               pop,
  output logic [TimeW-1:0]   edge_time_o,
  output logic [SlotW-1:0]   edge_slot_o,
  output logic               last_edge_o
);

  logic     q_push, q_full, q_valid, q_pop;
  q_entry_t q_wr_entry, q_rd_entry;

  // Front: running time and edge classification
  nrzts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .message_bits_i (message_bits_i),
    .restart_i      (restart_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_wr_entry)
  );

  // Decoupling queue
  nrzts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rd_entry)
  );

  // Back: boundary walk, slot counter and output register
  nrzts_back #(
    .BufferDepth (BufferDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .edge_time_o (edge_time_o),
    .edge_slot_o (edge_slot_o),
    .last_edge_o (last_edge_o)
  );

endmodule

// ===== tb/nrz_edge_timestamp_encoder_core_test.sv =====
// ============================================================================
// nrz_edge_timestamp_encoder_core_test
// Self-checking bench for the NRZ edge timestamp encoder core.
// ============================================================================
// Messages go in through the push/full side. The bench predicts every edge
// that each accepted message gives: timestamp, playback slot and end-of-message
// flag. Edge transfers popped from the block are checked in order against that
// prediction. The stimulus runs in four parts:
//   - a short directed set of patterns
//   - mixed random messages, with a long receiver hold-off that backs up the
//     input
//   - a short run of empty messages, the first one with restart
//   - dense alternating messages, without restart, until the slot index has
//     wrapped
// The sender runs in random bursts with gaps between them. The receiver
// switches among four pop patterns.
// ============================================================================
module nrz_edge_timestamp_encoder_core_test;
  import nrzts_pkg::*;

  localparam int unsigned SlotDepth     = DefaultBufferDepth;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MixedItems    = 60;
  localparam int unsigned DenseItems    = 230;
  // empty messages in a row: only the clock moves on
  localparam int unsigned EmptyRun      = 8;
  localparam int unsigned DrainCycles   = 40;

  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic [SlotW-1:0] slot;
    logic             last;
  } edge_rec_t;

  typedef enum int {PopAlways, PopHalf, PopCadence, PopSparse} pop_mode_e;

  // Predicts the edges of each accepted message and holds them until popped.
  class edge_book;
    logic [TimeW-1:0] line_time;
    logic [SlotW-1:0] next_slot;
    edge_rec_t        want_q[$];
    int               errors;
    int               slot_wraps;

    function new();
      line_time  = '0;
      next_slot  = '0;
      errors     = 0;
      slot_wraps = 0;
    endfunction

    function void book_edge(logic [TimeW-1:0] t);
      edge_rec_t   r;
      int unsigned nx;
      r.stamp = t;
      r.slot  = next_slot;
      r.last  = 1'b0;
      want_q.push_back(r);
      nx = int'(next_slot) + 1;
      if (nx >= SlotDepth) begin
        nx = 0;
        slot_wraps++;
      end
      next_slot = SlotW'(nx);
    endfunction

    function void note_message(logic [MsgBits-1:0] msg, logic rs);
      logic [TimeW-1:0] t;
      logic             level;
      int               n;
      edge_rec_t        r;
      if (rs) begin
        line_time = '0;
        next_slot = '0;
      end
      t     = line_time;
      level = msg[MsgBits-1];
      n     = 0;
      // boundary ahead of bit b lies BitUnits after the start of bit b+1
      for (int b = MsgBits - 2; b >= 0; b--) begin
        t = t + TimeW'(BitUnits);
        if (msg[b] != level) begin
          book_edge(t);
          n++;
        end
        level = msg[b];
      end
      t = t + TimeW'(BitUnits);
      if (level) begin
        book_edge(t);
        n++;
      end
      line_time = t + TimeW'(IdleUnits);
      if (n > 0) begin
        r = want_q.pop_back();
        r.last = 1'b1;
        want_q.push_back(r);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void check_transfer(logic [TimeW-1:0] t, logic [SlotW-1:0] s, logic l);
      edge_rec_t w;
      if (want_q.size() == 0) begin
        $error("unexpected edge transfer: edge_time %0d edge_slot %0d last_edge %0b",
               t, s, l);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (t !== w.stamp) begin
        $error("edge_time: expected %0d, got %0d", w.stamp, t);
        errors++;
      end
      if (s !== w.slot) begin
        $error("edge_slot: expected %0d, got %0d", w.slot, s);
        errors++;
      end
      if (l !== w.last) begin
        $error("last_edge: expected %0b, got %0b", w.last, l);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [MsgBits-1:0] message_bits_i;
  logic               restart_i;
  logic               empty;
  logic               pop;
  logic [TimeW-1:0]   edge_time_o;
  logic [SlotW-1:0]   edge_slot_o;
  logic               last_edge_o;

  edge_book book;
  bit       stalls_armed;  // set once the directed set is in; starts the hold-off
  int       burst_left;

  nrz_edge_timestamp_encoder_core #(
    .BufferDepth(SlotDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .message_bits_i(message_bits_i),
    .restart_i     (restart_i),
    .empty         (empty),
    .pop           (pop),
    .edge_time_o   (edge_time_o),
    .edge_slot_o   (edge_slot_o),
    .last_edge_o   (last_edge_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Offer one message from the next falling edge. The transfer happens at
  // the first rising edge where full is low. push is left high, so that a
  // following call keeps the sender going back to back.
  task automatic offer(logic [MsgBits-1:0] msg, logic rs);
    @(negedge clk_i);
    push           <= 1'b1;
    message_bits_i <= msg;
    restart_i      <= rs;
    do @(posedge clk_i); while (full);
    book.note_message(msg, rs);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  // Bursts of random length, each followed by a random gap. A gap of zero
  // joins two bursts into one unbroken stretch.
  task automatic pace();
    if (burst_left == 0) begin
      idle($urandom_range(0, 6));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // Alternating levels give the most edges. At random one bit is flipped,
  // which for an inner bit takes away a pair of edges.
  function automatic logic [MsgBits-1:0] alt_pattern();
    logic [MsgBits-1:0] m;
    m = $urandom_range(0, 1) ? 21'h155555 : 21'h0AAAAA;
    if ($urandom_range(0, 1)) m[$urandom_range(0, MsgBits - 1)] ^= 1'b1;
    return m;
  endfunction

  // Receiver: the pop pattern is drawn at random from four. There is one long
  // hold-off after the directed set, so that the input queue fills and
  // full comes up.
  initial begin : receiver
    pop_mode_e mode;
    int        cyc;
    int        hold_left;
    bit        held;
    logic      want_pop;
    pop       = 1'b0;
    mode      = PopAlways;
    cyc       = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) mode = pop_mode_e'($urandom_range(0, 3));
      if (stalls_armed && !held) begin
        held      = 1'b1;
        hold_left = HoldOffCycles;
      end
      case (mode)
        PopAlways:  want_pop = 1'b1;
        PopHalf:    want_pop = 1'($urandom_range(0, 1));
        PopCadence: want_pop = (cyc % 5) < 3;
        default:    want_pop = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        want_pop = 1'b0;
      end
      pop <= want_pop;
      cyc++;
    end
  end

  // Edge transfers are checked at the edge where they happen.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) book.check_transfer(edge_time_o, edge_slot_o, last_edge_o);
  end

  initial begin : stimulus
    int                 count;
    logic [MsgBits-1:0] msg;
    logic               rs;
    book           = new();
    stalls_armed   = 1'b0;
    burst_left     = 0;
    push           = 1'b0;
    message_bits_i = '0;
    restart_i      = 1'b0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed set, back to back
    offer(21'h1FFFFF, 1'b0);  // one level all through: the end edge only
    offer(21'h000000, 1'b0);  // no level change: no edge, the clock still moves on
    offer(21'h155555, 1'b0);  // the most edges: 20 changes plus the end edge
    offer(21'h0AAAAA, 1'b0);  // 20 changes, ends low
    offer(21'h100000, 1'b1);  // restart; a single fall after the first bit
    offer(21'h000001, 1'b0);  // rise at the last boundary, then the end edge
    offer(21'h0FFFFF, 1'b0);  // change into the first bit is not an edge
    offer(21'h1FFFFE, 1'b0);
    offer(21'h000000, 1'b1);  // restart on an empty message
    offer(21'h1FFFFF, 1'b1);
    offer(21'h100001, 1'b0);
    offer(21'h0F0F0F, 1'b0);
    offer(21'h1C0003, 1'b1);
    offer(21'h155555, 1'b0);
    offer(21'h155555, 1'b0);
    stalls_armed = 1'b1;

    // Mixed random content with frequent restarts
    for (count = 0; count < MixedItems; count++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: msg = MsgBits'($urandom);
        4, 5:       msg = alt_pattern();
        6:          msg = $urandom_range(0, 1) ? '0 : '1;
        7:          msg = MsgBits'(1) << $urandom_range(0, MsgBits - 1);
        8:          msg = ~(MsgBits'(1) << $urandom_range(0, MsgBits - 1));
        default:    msg = ('1 >> $urandom_range(0, MsgBits)) << $urandom_range(0, 8);
      endcase
      rs = ($urandom_range(0, 7) == 0);
      pace();
      offer(msg, rs);
    end

    // Empty messages; the first one restarts time and slot
    for (count = 0; count < EmptyRun; count++) begin
      pace();
      offer('0, count == 0);
    end

    // Dense messages without restart.
    // They go on until the slot index has wrapped at the buffer depth.
    count = 0;
    while (count < DenseItems || book.slot_wraps == 0) begin
      msg = ($urandom_range(0, 9) == 0) ? MsgBits'($urandom) : alt_pattern();
      pace();
      offer(msg, 1'b0);
      count++;
    end
    idle(1);

    while (book.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 200000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nrzts_pkg.sv
rtl/nrzts_front.sv
rtl/nrzts_queue.sv
rtl/nrzts_back.sv
rtl/nrz_edge_timestamp_encoder_core.sv
tb/nrz_edge_timestamp_encoder_core_test.sv
